[rtl/core/assert_macros.svh]
// Assertion macros used by lhg_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define LHG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define LHG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/lhg_pkg.sv]
// Package for the load hotplug governor: widths, codes, reset values,
// controller/datapath command types. No dependencies.
`timescale 1ns / 1ps

package lhg_pkg;

	localparam int LOAD_W      = 7;
	localparam int FREQ_W      = 22;
	localparam int REQ_W       = 2;
	localparam int ACT_W       = 3;
	localparam int CORE_W      = 2;
	localparam int STREAK_W    = 6;
	localparam int MASK_W      = 4;   // width of the reported online mask
	localparam int CNT_W       = 3;
	localparam int SUM_W       = 9;   // four loads of at most 100
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 7;
	localparam int LIM_W       = 6;
	localparam int FIELD_CORES = 4;   // cores that have fields on the item
	localparam int DIV3_MUL_W  = 10;
	localparam int DIV3_SHIFT  = 11;
	localparam int PROD_W      = SUM_W + DIV3_MUL_W;

	localparam logic [LOAD_W-1:0]     LOAD_CAP        = 7'd100;
	localparam logic [LOAD_W-1:0]     HIGH_LOAD       = 7'd95;
	localparam logic [LIM_W-1:0]      LIMIT_CAP       = 6'd40;
	localparam logic [STREAK_W-1:0]   HIGH_MIN_STREAK = 6'd2;
	localparam logic [STREAK_W-1:0]   STREAK_MAX      = 6'd63;
	localparam logic [CNT_W-1:0]      FROZEN_MAX      = 3'd2;
	localparam logic [CNT_W-1:0]      UNPLUG_FLOOR    = 3'd2;
	// floor(x/3) == (x*683)>>11 for every x below 2048
	localparam logic [DIV3_MUL_W-1:0] DIV3_MUL        = 10'd683;

	// event kinds
	localparam logic [REQ_W-1:0] REQ_TICK     = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DISP_OFF = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DISP_ON  = 2'd2;

	// reported actions
	localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PLUG   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_UNPLUG = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SHED   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_RESUME = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UP_THR     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CORES  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSP_CORES = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UP_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN_LIMIT = 3'd5;

	// register reset values
	localparam logic [LOAD_W-1:0] RST_UP_THR     = 7'd80;
	localparam logic [CNT_W-1:0]  RST_MAX_CORES  = 3'd4;
	localparam logic [CNT_W-1:0]  RST_SUSP_CORES = 3'd2;
	localparam logic [LIM_W-1:0]  RST_UP_LIMIT   = 6'd4;
	localparam logic [LIM_W-1:0]  RST_DOWN_LIMIT = 6'd10;

	typedef struct packed {
		logic capture;  // item accepted: latch request, frequencies, sum and count
		logic avg;      // divide sum by online count
		logic apply;    // decide and update state
		logic shed;     // one display-off shed step
		logic emit;     // load the result register
	} lhg_cmd_t;

	typedef struct packed {
		logic shed_req;   // applied item is an enabled display-off
		logic shed_done;  // shed walk finishes this step
	} lhg_stat_t;

	function automatic logic [STREAK_W-1:0] sat_inc(input logic [STREAK_W-1:0] v);
		return (v < STREAK_MAX) ? v + 1'b1 : v;
	endfunction

endpackage

[rtl/core/lhg_channels.sv]
// Channel interfaces of the load hotplug governor: event in, result out,
// register write. Depends on lhg_pkg.
`timescale 1ns / 1ps

interface lhg_evt_if import lhg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [LOAD_W-1:0] load_core0;
	logic [LOAD_W-1:0] load_core1;
	logic [LOAD_W-1:0] load_core2;
	logic [LOAD_W-1:0] load_core3;
	logic [FREQ_W-1:0] freq_core2;
	logic [FREQ_W-1:0] freq_core3;

	modport source (output valid, req_type, load_core0, load_core1, load_core2,
		load_core3, freq_core2, freq_core3, input ready);
	modport sink (input valid, req_type, load_core0, load_core1, load_core2,
		load_core3, freq_core2, freq_core3, output ready);
endinterface

interface lhg_res_if import lhg_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [MASK_W-1:0]   online_after;
	logic [ACT_W-1:0]    action;
	logic [CORE_W-1:0]   acted_core;
	logic [LOAD_W-1:0]   load_average;
	logic [STREAK_W-1:0] up_streak;
	logic [STREAK_W-1:0] down_streak;
	logic                in_suspend;

	modport source (output valid, online_after, action, acted_core, load_average,
		up_streak, down_streak, in_suspend, input ready);
	modport sink (input valid, online_after, action, acted_core, load_average,
		up_streak, down_streak, in_suspend, output ready);
endinterface

interface lhg_cfg_if import lhg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/load_hotplug_governor.sv]
// Top level of the load hotplug governor.
// Depends on lhg_pkg, lhg_channels, lhg_ctrl and lhg_datapath.
`timescale 1ns / 1ps

// Load-driven core hotplug governor. Each event item (tick, display off,
// display on) yields exactly one result item with the online mask, the
// action taken, the core acted on, the tick's average load, both streak
// counters and the suspended flag, all as they stand after the event.
// Steps: a tick, display-on or ignored item passes capture with load sum,
// divide by online count, decide and result register; a display-off item
// also runs the shed walk between decide and result register, which visits
// one core index per cycle. One item is in work at a
// time; the next item is taken once the previous one has reached the
// result register, even while that result is still waiting downstream.
// Register writes are taken every cycle (cfg.ready is tied high) and must
// only be issued while no item is in work. After reset all NUM_CORES cores
// are online and the governor is disabled.
module load_hotplug_governor import lhg_pkg::*; #(
	parameter int NUM_CORES = 4   // 2..4
) (
	input  logic      clk,
	input  logic      arst_n,
	lhg_evt_if.sink   evt,
	lhg_res_if.source res,
	lhg_cfg_if.sink   cfg
);

	lhg_cmd_t  cmd;   // controller -> datapath
	lhg_stat_t stat;  // datapath -> controller

	// registers live in flops, any write lands in the following cycle
	assign cfg.ready = 1'b1;

	lhg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lhg_datapath #(
		.NUM_CORES (NUM_CORES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.req_type     (evt.req_type),
		.load_core0   (evt.load_core0),
		.load_core1   (evt.load_core1),
		.load_core2   (evt.load_core2),
		.load_core3   (evt.load_core3),
		.freq_core2   (evt.freq_core2),
		.freq_core3   (evt.freq_core3),
		.online_after (res.online_after),
		.action       (res.action),
		.acted_core   (res.acted_core),
		.load_average (res.load_average),
		.up_streak    (res.up_streak),
		.down_streak  (res.down_streak),
		.in_suspend   (res.in_suspend)
	);

endmodule

[rtl/core/lhg_ctrl.sv]
// Sequencing controller of the load hotplug governor.
// Depends on lhg_pkg.
`timescale 1ns / 1ps

module lhg_ctrl import lhg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      evt_valid,
	output logic      evt_ready,
	output logic      res_valid,
	input  logic      res_ready,
	input  lhg_stat_t stat,
	output lhg_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_AVG   = 3'd1;
	localparam logic [2:0] ST_APPLY = 3'd2;
	localparam logic [2:0] ST_SHED  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       res_valid_q;

	assign evt_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		cmd.capture = evt_valid && (state_q == ST_IDLE);
		cmd.avg     = (state_q == ST_AVG);
		cmd.apply   = (state_q == ST_APPLY);
		cmd.shed    = (state_q == ST_SHED);
		// result register is free or drains this cycle
		cmd.emit    = (state_q == ST_EMIT) && (!res_valid_q || res_ready);
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (evt_valid) state_nx = ST_AVG;
			end
			ST_AVG:   state_nx = ST_APPLY;
			ST_APPLY: state_nx = stat.shed_req ? ST_SHED : ST_EMIT;
			ST_SHED: begin
				if (stat.shed_done) state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (cmd.emit) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.emit) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/core/lhg_datapath.sv]
// Datapath of the load hotplug governor: registers, governor state,
// averaging, plug/unplug choice, result register. Depends on lhg_pkg.
`timescale 1ns / 1ps

module lhg_datapath import lhg_pkg::*; #(
	parameter int NUM_CORES = 4,
	localparam int IDX_W = $clog2(NUM_CORES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lhg_cmd_t              cmd,
	output lhg_stat_t             stat,
	// register write
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// item fields
	input  logic [REQ_W-1:0]      req_type,
	input  logic [LOAD_W-1:0]     load_core0,
	input  logic [LOAD_W-1:0]     load_core1,
	input  logic [LOAD_W-1:0]     load_core2,
	input  logic [LOAD_W-1:0]     load_core3,
	input  logic [FREQ_W-1:0]     freq_core2,
	input  logic [FREQ_W-1:0]     freq_core3,
	// result fields
	output logic [MASK_W-1:0]     online_after,
	output logic [ACT_W-1:0]      action,
	output logic [CORE_W-1:0]     acted_core,
	output logic [LOAD_W-1:0]     load_average,
	output logic [STREAK_W-1:0]   up_streak,
	output logic [STREAK_W-1:0]   down_streak,
	output logic                  in_suspend
);

	// registers
	logic                enable_q;
	logic [LOAD_W-1:0]   up_thr_q;
	logic [CNT_W-1:0]    max_cores_q;
	logic [CNT_W-1:0]    susp_cores_q;
	logic [LIM_W-1:0]    up_lim_q;
	logic [LIM_W-1:0]    dn_lim_q;

	// governor state
	logic [NUM_CORES-1:0] online_q;
	logic                 susp_q;
	logic [STREAK_W-1:0]  up_q;
	logic [STREAK_W-1:0]  down_q;

	// item in flight
	logic [REQ_W-1:0]  req_q;
	logic [FREQ_W-1:0] freq_q [2:FIELD_CORES-1];
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  n_q;
	logic [LOAD_W-1:0] avg_q;
	logic [IDX_W-1:0]  shed_idx_q;
	logic [ACT_W-1:0]  act_q;
	logic [CORE_W-1:0] core_q;
	logic [LOAD_W-1:0] avg_res_q;

	// result register
	logic [MASK_W-1:0]   out_online_q;
	logic [ACT_W-1:0]    out_act_q;
	logic [CORE_W-1:0]   out_core_q;
	logic [LOAD_W-1:0]   out_avg_q;
	logic [STREAK_W-1:0] out_up_q;
	logic [STREAK_W-1:0] out_down_q;
	logic                out_susp_q;

	logic [LOAD_W-1:0]   ld_in [FIELD_CORES];
	logic [CNT_W-1:0]    cnt;
	logic [SUM_W-1:0]    sum_c;
	logic [PROD_W-1:0]   prod3;
	logic [LOAD_W-1:0]   avg_c;
	logic [LOAD_W-1:0]   thr;
	logic [LIM_W-1:0]    upl;
	logic [LIM_W-1:0]    dnl;
	logic [STREAK_W-1:0] up_inc;
	logic [STREAK_W-1:0] dn_inc;
	logic                plug_found;
	logic [IDX_W-1:0]    plug_idx;
	logic                un_found;
	logic [IDX_W-1:0]    un_idx;
	logic [FREQ_W-1:0]   un_low;
	logic                do_plug;
	logic                do_unplug;
	logic                shed_stop;

	logic [NUM_CORES-1:0] nx_online;
	logic                 nx_susp;
	logic [STREAK_W-1:0]  nx_up;
	logic [STREAK_W-1:0]  nx_dn;
	logic [ACT_W-1:0]     nx_act;
	logic [CORE_W-1:0]    nx_core;
	logic [LOAD_W-1:0]    nx_avg;

	assign ld_in[0] = load_core0;
	assign ld_in[1] = load_core1;
	assign ld_in[2] = load_core2;
	assign ld_in[3] = load_core3;

	// online count and sum of capped loads of online cores
	always_comb begin
		cnt   = '0;
		sum_c = '0;
		for (int i = 0; i < NUM_CORES; i++) begin
			cnt = cnt + CNT_W'(online_q[i]);
			if (online_q[i])
				sum_c = sum_c + SUM_W'((ld_in[i] > LOAD_CAP) ? LOAD_CAP : ld_in[i]);
		end
	end

	// divide by 1..4 online cores; 3 via reciprocal multiply
	assign prod3 = PROD_W'(sum_q) * PROD_W'(DIV3_MUL);

	always_comb begin
		case (n_q)
			3'd1:    avg_c = LOAD_W'(sum_q);
			3'd2:    avg_c = LOAD_W'(sum_q >> 1);
			3'd3:    avg_c = LOAD_W'(prod3 >> DIV3_SHIFT);
			3'd4:    avg_c = LOAD_W'(sum_q >> 2);
			default: avg_c = '0;
		endcase
	end

	assign thr    = (up_thr_q > LOAD_CAP) ? LOAD_CAP : up_thr_q;
	assign upl    = (up_lim_q > LIMIT_CAP) ? LIMIT_CAP : up_lim_q;
	assign dnl    = (dn_lim_q > LIMIT_CAP) ? LIMIT_CAP : dn_lim_q;
	assign up_inc = sat_inc(up_q);
	assign dn_inc = sat_inc(down_q);

	// lowest offline core above core 0
	always_comb begin
		plug_found = 1'b0;
		plug_idx   = '0;
		for (int i = NUM_CORES - 1; i >= 1; i--) begin
			if (!online_q[i]) begin
				plug_found = 1'b1;
				plug_idx   = IDX_W'(i);
			end
		end
	end

	// slowest online core above core 1, ties to the lower index
	always_comb begin
		un_found = 1'b0;
		un_idx   = '0;
		un_low   = '1;
		for (int i = 2; i < NUM_CORES; i++) begin
			if (online_q[i] && (!un_found || (freq_q[i] < un_low))) begin
				un_found = 1'b1;
				un_idx   = IDX_W'(i);
				un_low   = freq_q[i];
			end
		end
	end

	// decision for the applied item
	always_comb begin
		nx_online = online_q;
		nx_susp   = susp_q;
		nx_up     = up_q;
		nx_dn     = down_q;
		nx_act    = ACT_NONE;
		nx_core   = '0;
		nx_avg    = '0;
		do_plug   = 1'b0;
		do_unplug = 1'b0;
		if (enable_q) begin
			case (req_q)
				REQ_TICK: begin
					if (!susp_q && (max_cores_q != FROZEN_MAX)) begin
						nx_avg = avg_q;
						if (avg_q >= thr) begin
							nx_up   = up_inc;
							do_plug = (up_inc > STREAK_W'(upl));
						end else if ((avg_q > HIGH_LOAD) && (up_q >= HIGH_MIN_STREAK)) begin
							nx_up   = up_inc;
							do_plug = 1'b1;
						end else begin
							nx_dn     = dn_inc;
							do_unplug = (dn_inc > STREAK_W'(dnl));
						end
						if (do_plug) begin
							nx_up = '0;
							nx_dn = '0;
							if ((cnt != max_cores_q) && plug_found) begin
								nx_online[plug_idx] = 1'b1;
								nx_act  = ACT_PLUG;
								nx_core = CORE_W'(plug_idx);
							end
						end
						if (do_unplug) begin
							nx_up = '0;
							nx_dn = '0;
							if ((cnt != UNPLUG_FLOOR) && un_found) begin
								nx_online[un_idx] = 1'b0;
								nx_act  = ACT_UNPLUG;
								nx_core = CORE_W'(un_idx);
							end
						end
					end
				end
				REQ_DISP_OFF: begin
					nx_susp = 1'b1;
					nx_act  = ACT_SHED;
				end
				REQ_DISP_ON: begin
					nx_susp = 1'b0;
					if (!online_q[1]) begin
						nx_online[1] = 1'b1;
						nx_act       = ACT_RESUME;
						nx_core      = CORE_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// display-off walk: one core index per cycle, stop once count matches or the last index is reached
	assign shed_stop = (cnt == susp_cores_q);

	always_comb begin
		stat.shed_req  = enable_q && (req_q == REQ_DISP_OFF);
		stat.shed_done = shed_stop || (shed_idx_q == IDX_W'(NUM_CORES - 1));
	end

	// registers and governor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			up_thr_q     <= RST_UP_THR;
			max_cores_q  <= RST_MAX_CORES;
			susp_cores_q <= RST_SUSP_CORES;
			up_lim_q     <= RST_UP_LIMIT;
			dn_lim_q     <= RST_DOWN_LIMIT;
			online_q     <= '1;
			susp_q       <= 1'b0;
			up_q         <= '0;
			down_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENABLE:     enable_q     <= cfg_data[0];
					CFG_UP_THR:     up_thr_q     <= cfg_data;
					CFG_MAX_CORES:  max_cores_q  <= cfg_data[CNT_W-1:0];
					CFG_SUSP_CORES: susp_cores_q <= cfg_data[CNT_W-1:0];
					CFG_UP_LIMIT:   up_lim_q     <= cfg_data[LIM_W-1:0];
					CFG_DOWN_LIMIT: dn_lim_q     <= cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (cmd.apply) begin
				online_q <= nx_online;
				susp_q   <= nx_susp;
				up_q     <= nx_up;
				down_q   <= nx_dn;
			end else if (cmd.shed) begin
				if (!shed_stop && (shed_idx_q != '0))
					online_q[shed_idx_q] <= 1'b0;
			end
		end
	end

	// item in flight and shed index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shed_idx_q <= '0;
		end else if (cmd.apply) begin
			shed_idx_q <= '0;
		end else if (cmd.shed) begin
			shed_idx_q <= shed_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q     <= req_type;
			freq_q[2] <= freq_core2;
			freq_q[3] <= freq_core3;
			sum_q     <= sum_c;
			n_q       <= cnt;
		end
		if (cmd.avg) avg_q <= avg_c;
		if (cmd.apply) begin
			act_q     <= nx_act;
			core_q    <= nx_core;
			avg_res_q <= nx_avg;
		end
		if (cmd.emit) begin
			out_online_q <= MASK_W'(online_q);
			out_act_q    <= act_q;
			out_core_q   <= core_q;
			out_avg_q    <= avg_res_q;
			out_up_q     <= up_q;
			out_down_q   <= down_q;
			out_susp_q   <= susp_q;
		end
	end

	assign online_after = out_online_q;
	assign action       = out_act_q;
	assign acted_core   = out_core_q;
	assign load_average = out_avg_q;
	assign up_streak    = out_up_q;
	assign down_streak  = out_down_q;
	assign in_suspend   = out_susp_q;

endmodule

[rtl/core/lhg_checker.sv]
// Port-level checks for the load hotplug governor, bound to the top level.
// Depends on lhg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lhg_checker import lhg_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              evt_valid,
	input logic              evt_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic [MASK_W-1:0] res_online_after,
	input logic [ACT_W-1:0]  res_action,
	input logic [CORE_W-1:0] res_acted_core,
	input logic [LOAD_W-1:0] res_load_average
);

	// an accepted item keeps the block busy for the next cycle
	`LHG_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, evt_valid && evt_ready, !evt_ready, "item accepted on back-to-back cycles")

	// a stalled result stays offered
	`LHG_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid, "result dropped while stalled")

	// core 0 is never taken down
	`LHG_ASSERT_NOW(a_core0_online, clk, arst_n, res_valid, res_online_after[0], "core 0 reported offline")

	// no core index without a plug, unplug or resume action
	`LHG_ASSERT_NOW(a_core_idle, clk, arst_n, res_valid && (res_action == ACT_NONE || res_action == ACT_SHED), res_acted_core == '0, "core index without core action")

	`LHG_ASSERT_NOW(a_avg_range, clk, arst_n, res_valid, res_load_average <= LOAD_CAP, "average load above cap")

endmodule

bind load_hotplug_governor lhg_checker u_lhg_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.evt_valid        (evt.valid),
	.evt_ready        (evt.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_online_after (res.online_after),
	.res_action       (res.action),
	.res_acted_core   (res.acted_core),
	.res_load_average (res.load_average)
);
